FILE: hw/rtl/lsp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared payload types, operation codes, status codes and register map.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_BADPOS   = 2'd3;

  localparam int unsigned APB_AW        = 3;
  localparam logic        REG_CAPACITY  = 1'b0;
  localparam logic [3:0]  CAPACITY_RST  = 4'd5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] push_value;
    logic [3:0]         peek_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [3:0]         fill_level;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lsp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module lsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lsp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack controller
// Sequences accept, memory access and result load for one transaction.
// ----------------------------------------------------------------------------
module lsp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lsp_pkg::stat_t stat_i,
  output lsp_pkg::cmd_t      cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q, in_ready_d;

  always_comb begin
    state_d      = state_q;
    in_ready_d   = in_ready_q;
    cmd_o.accept = 1'b0;
    cmd_o.load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_q) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RESP;
          in_ready_d   = 1'b0;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
          in_ready_d = 1'b1;
        end
      end
      default: begin
        state_d    = S_IDLE;
        in_ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= in_ready_d;
    end
  end

  assign in_ready_o = in_ready_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lsp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack datapath
// Capacity register, entry count, address generation, entry RAM and
// result register.
// ----------------------------------------------------------------------------
module lsp_dp #(
  parameter int unsigned MAX_DEPTH = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lsp_pkg::cmd_t               cmd_i,
  output lsp_pkg::stat_t                   stat_o,
  input  wire lsp_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output lsp_pkg::out_item_t               out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lsp_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata
);

  localparam int unsigned CntW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AddrW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CmpW = (CntW > 4) ? CntW : 4;

  logic [3:0]      capacity_q;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      status_q, status_d;
  logic            rd_sel_q, rd_sel_d;
  logic [3:0]      fill_q;

  logic                out_valid_q;
  lsp_pkg::out_item_t  out_data_q;

  logic [CmpW-1:0] cap_ext, max_ext, usable, cnt_ext, pos_ext, cnt_dec, peek_idx, cnt_next;
  logic            ram_we, ram_re;
  logic [AddrW-1:0] ram_addr;
  logic [31:0]     ram_rdata;
  logic            reg_hit;

  assign cap_ext  = CmpW'(capacity_q);
  assign max_ext  = CmpW'(MAX_DEPTH);
  assign usable   = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign cnt_ext  = CmpW'(count_q);
  assign pos_ext  = CmpW'(in_data_i.peek_position);
  assign cnt_dec  = cnt_ext - CmpW'(1);
  assign peek_idx = cnt_ext - pos_ext;
  assign cnt_next = CmpW'(count_d);

  always_comb begin
    count_d  = count_q;
    status_d = lsp_pkg::ST_OK;
    rd_sel_d = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = cnt_ext[AddrW-1:0];
    case (in_data_i.opcode)
      lsp_pkg::OP_PUSH: begin
        if (cnt_ext >= usable) begin
          status_d = lsp_pkg::ST_OVERFLOW;
        end else begin
          ram_we  = cmd_i.accept;
          count_d = count_q + CntW'(1);
        end
      end
      lsp_pkg::OP_POP: begin
        if (count_q == '0) begin
          status_d = lsp_pkg::ST_EMPTY;
        end else begin
          ram_re   = cmd_i.accept;
          rd_sel_d = 1'b1;
          ram_addr = cnt_dec[AddrW-1:0];
          count_d  = count_q - CntW'(1);
        end
      end
      lsp_pkg::OP_PEEK: begin
        if (in_data_i.peek_position == 4'd0 || pos_ext > cnt_ext) begin
          status_d = lsp_pkg::ST_BADPOS;
        end else begin
          ram_re   = cmd_i.accept;
          rd_sel_d = 1'b1;
          ram_addr = peek_idx[AddrW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  lsp_ram #(
    .WIDTH(32),
    .DEPTH(MAX_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(in_data_i.push_value),
    .rdata_o(ram_rdata)
  );

  assign reg_hit = (paddr[2] == lsp_pkg::REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= lsp_pkg::CAPACITY_RST;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && reg_hit) begin
        capacity_q <= pwdata[3:0];
      end
      if (cmd_i.accept) begin
        count_q <= count_d;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      status_q <= status_d;
      rd_sel_q <= rd_sel_d;
      fill_q   <= cnt_next[3:0];
    end
    if (cmd_i.load) begin
      out_data_q.read_value <= rd_sel_q ? signed'(ram_rdata) : 32'sd0;
      out_data_q.status     <= status_q;
      out_data_q.fill_level <= fill_q;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign prdata          = reg_hit ? {28'd0, capacity_q} : 32'd0;

endmodule
`default_nettype wire

FILE: hw/rtl/lifo_stack_with_peek_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack with peek
// Stack of signed 32-bit words with push, pop and peek-from-top.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one operation per
//   transaction: push, pop or peek at a position counted from the top.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns one result per
//   operation: word read, status and fill level after the operation.
//   Capacity is set through the APB port at byte address 0 (4 bits, values
//   above MAX_DEPTH act as MAX_DEPTH); write it only while the block is idle.
//   The input transaction registers the entry RAM read, status and fill
//   level; the result is then loaded into the output register once it is free.
//   One operation is in flight at a time, so a new operation is not accepted
//   until the previous result has been loaded into the output register.
//   A finished result sits in the output register; the next operation is
//   accepted while it waits, and its own result stalls until the receiver
//   takes the previous one.
//   Reset empties the stack and sets capacity to 5; entry contents are not
//   cleared and are never read before being written.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_unit #(
  parameter int unsigned MAX_DEPTH = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire lsp_pkg::in_item_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output lsp_pkg::out_item_t              out_data_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lsp_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  lsp_pkg::cmd_t  cmd;
  lsp_pkg::stat_t stat;

  lsp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lsp_dp #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
  );

  assign pready = 1'b1;

endmodule
`default_nettype wire

FILE: hw/rtl/lsp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack port checker
// Observes the top-level ports and flags sequencing and result errors.
// ----------------------------------------------------------------------------
module lsp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire lsp_pkg::out_item_t out_data_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a transaction in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != lsp_pkg::ST_OK)
      |-> (out_data_o.read_value == 32'sd0))
    else $error("nonzero read value on error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == lsp_pkg::ST_EMPTY)
      |-> (out_data_o.fill_level == 4'd0))
    else $error("empty status with nonzero fill level");

endmodule

bind lifo_stack_with_peek_unit lsp_checker u_lsp_checker (.*);
`default_nettype wire
